[hdl/pcp_pkg.sv]
// Shared constants, types and helper functions for the pixel component projection block.
package pcp_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int MAX_COMPONENTS = 16;
	localparam int CIDX_W         = $clog2(MAX_COMPONENTS);
	localparam int CNT_W          = $clog2(MAX_COMPONENTS + 1);
	localparam int SUM_W          = 37;
	localparam int SQ_W           = 52;
	localparam int CW             = 35;   // CORDIC datapath width
	localparam int CORDIC_STEPS   = 31;
	localparam int PW             = 66;   // multiplier product width

	typedef logic [2:0] mode_t;

	localparam mode_t MODE_MIN   = 3'd0;
	localparam mode_t MODE_MEAN  = 3'd1;
	localparam mode_t MODE_MAX   = 3'd2;
	localparam mode_t MODE_MAG   = 3'd3;
	localparam mode_t MODE_PH_SR = 3'd4;
	localparam mode_t MODE_PH_UR = 3'd5;
	localparam mode_t MODE_PH_SD = 3'd6;
	localparam mode_t MODE_PH_UD = 3'd7;

	localparam logic signed [CW-1:0] ANG_PI_2   = 35'sd1686629713;
	localparam logic signed [CW-1:0] ANG_TWO_PI = 35'sd6746518852;
	localparam logic [29:0]          DEG_PER_RAD_Q24 = 30'd961263669;

	// arctangent of 2^-i in Q2.30
	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'h3243F6A8;
			5'd1:  v = 30'h1DAC6705;
			5'd2:  v = 30'h0FADBAFC;
			5'd3:  v = 30'h07F56EA6;
			5'd4:  v = 30'h03FEAB76;
			5'd5:  v = 30'h01FFD55B;
			5'd6:  v = 30'h00FFFAAA;
			5'd7:  v = 30'h007FFF55;
			5'd8:  v = 30'h003FFFEA;
			5'd9:  v = 30'h001FFFFD;
			5'd10: v = 30'h000FFFFF;
			5'd11: v = 30'h0007FFFF;
			5'd12: v = 30'h0003FFFF;
			5'd13: v = 30'h0001FFFF;
			5'd14: v = 30'h0000FFFF;
			5'd15: v = 30'h00007FFF;
			5'd16: v = 30'h00003FFF;
			5'd17: v = 30'h00001FFF;
			5'd18: v = 30'h00000FFF;
			5'd19: v = 30'h000007FF;
			5'd20: v = 30'h000003FF;
			5'd21: v = 30'h000001FF;
			5'd22: v = 30'h000000FF;
			5'd23: v = 30'h0000007F;
			5'd24: v = 30'h0000003F;
			5'd25: v = 30'h0000001F;
			5'd26: v = 30'h0000000F;
			5'd27: v = 30'h00000008;
			5'd28: v = 30'h00000004;
			5'd29: v = 30'h00000002;
			5'd30: v = 30'h00000001;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		logic signed [31:0] r;
		if (v > PW'(signed'(32'sh7FFFFFFF)))
			r = 32'sh7FFFFFFF;
		else if (v < PW'(signed'(32'sh80000000)))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

[hdl/pcp_if.sv]
// Valid/ready channel interfaces for the pixel component projection block.
interface pcp_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample;
	logic               sample_finite;
	logic               last_component;
	modport source (output valid, sample, sample_finite, last_component, input ready);
	modport sink   (input valid, sample, sample_finite, last_component, output ready);
endinterface

interface pcp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] projected_value;
	logic [4:0]         ignored_count;
	modport source (output valid, projected_value, ignored_count, input ready);
	modport sink   (input valid, projected_value, ignored_count, output ready);
endinterface

interface pcp_cfg_if;
	logic             valid;
	logic             ready;
	pcp_pkg::mode_t   projection_mode;
	modport source (output valid, projection_mode, input ready);
	modport sink   (input valid, projection_mode, output ready);
endinterface

[hdl/pixel_component_projection.sv]
// Pixel component projection: per-pixel min, mean, max, magnitude or phase.
//
//  channel | dir | payload                                   | request taken when
//  in_ch   | in  | sample, sample_finite, last_component     | valid & ready
//  out_ch  | out | projected_value, ignored_count            | valid & ready
//  cfg     | in  | projection_mode                           | valid & ready (always ready)
//
// Each component is accepted, squared in the shared multiplier and accumulated, and no
// new component is taken until it is through. The final component adds the finish: the
// stored value for min/max, a 37-step restoring divider for mean, a 32-step square root
// for magnitude, a 31-step CORDIC and two-part degree multiply for phase, then hand-over.
// Reset clears the mode to min and empties the pixel accumulators.
// A stalled output only holds the block once the next pixel is ready to finish.
module pixel_component_projection (
	input  logic        clk,
	input  logic        arst_n,
	pcp_in_if.sink      in_ch,
	pcp_out_if.source   out_ch,
	pcp_cfg_if.sink     cfg
);
	import pcp_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQMUL = 4'd1;
	localparam logic [3:0] ST_SQACC = 4'd2;
	localparam logic [3:0] ST_START = 4'd3;
	localparam logic [3:0] ST_DIV   = 4'd4;
	localparam logic [3:0] ST_MFIN  = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_SFIN  = 4'd7;
	localparam logic [3:0] ST_CORD  = 4'd8;
	localparam logic [3:0] ST_WRAP  = 4'd9;
	localparam logic [3:0] ST_DEG1  = 4'd10;
	localparam logic [3:0] ST_DEG2  = 4'd11;
	localparam logic [3:0] ST_DEG3  = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	logic [3:0]               state_q;
	mode_t                    mode_q;
	logic signed [31:0]       min_q, max_q, re_q, im_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]          sq_q;
	logic [CNT_W-1:0]         fin_cnt_q, skip_q;
	logic [CIDX_W-1:0]        cidx_q;
	logic [1:0]               pf_q;
	logic                     end_q;
	logic [31:0]              m_q;
	logic signed [PW-1:0]     prod_q, acc_q;
	logic [5:0]               ctr_q;
	logic [SUM_W-1:0]         num_q;
	logic [CNT_W-1:0]         rem_q;
	logic                     neg_q;
	logic [62:0]              v_q, r_q, bit_q;
	logic signed [CW-1:0]     x_q, y_q, z_q;
	logic signed [31:0]       res_q;
	logic                     ovalid_q;
	logic signed [31:0]       oval_q;
	logic [4:0]               ocnt_q;

	logic                     in_acc;
	logic signed [32:0]       mul_a, mul_b;

	assign in_acc       = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = ovalid_q;
	assign out_ch.projected_value = oval_q;
	assign out_ch.ignored_count   = ocnt_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = 33'sd0;
		mul_b = signed'({3'b000, DEG_PER_RAD_Q24});
		case (state_q)
			ST_SQMUL: begin
				mul_a = signed'({1'b0, m_q});
				mul_b = signed'({1'b0, m_q});
			end
			ST_DEG1: mul_a = signed'({16'b0, z_q[16:0]});
			// high part of the angle keeps its sign
			ST_DEG2: mul_a = 33'(signed'(z_q[CW-1:17]));
			default: mul_a = 33'sd0;
		endcase
	end

	// divider step
	logic [CNT_W:0]   div_t;
	logic             div_ge;
	assign div_t  = {rem_q, num_q[SUM_W-1]};
	assign div_ge = div_t >= {1'b0, fin_cnt_q};

	// square root step
	logic [62:0] sq_try;
	logic        sq_ge;
	assign sq_try = r_q + bit_q;
	assign sq_ge  = v_q >= sq_try;

	// CORDIC step
	logic signed [CW-1:0] cx_d, cy_d, c_atan;
	assign cx_d   = y_q >>> ctr_q[4:0];
	assign cy_d   = x_q >>> ctr_q[4:0];
	assign c_atan = signed'({5'b0, atan_q30(ctr_q[4:0])});

	// finish helpers
	logic [SUM_W-1:0]     sum_mag;
	logic signed [PW-1:0] deg_tot, wrap_z, mean_q;
	logic signed [CW-1:0] z_adj;
	logic [32:0]          sq_res;
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign z_adj   = ((mode_q inside {MODE_PH_UR, MODE_PH_UD}) && z_q < 0)
		? z_q + ANG_TWO_PI : z_q;
	assign wrap_z  = (PW'(z_adj) + (PW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
	assign deg_tot = ((prod_q <<< 17) + acc_q + (PW'(1) <<< (53 - FRAC_BITS)))
		>>> (54 - FRAC_BITS);
	assign mean_q  = neg_q ? -signed'(PW'(num_q)) : signed'(PW'(num_q));
	assign sq_res  = r_q[32:0] + 33'(v_q > r_q);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_MIN;
		else if (cfg.valid && cfg.ready)
			mode_q <= cfg.projection_mode;
	end

	// multiplier with registered product
	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a * mul_b);
	end

	// sequencer and pixel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			min_q     <= 32'sh7FFFFFFF;
			max_q     <= 32'sh80000000;
			sum_q     <= '0;
			sq_q      <= '0;
			fin_cnt_q <= '0;
			skip_q    <= '0;
			cidx_q    <= '0;
			pf_q      <= '0;
			re_q      <= '0;
			im_q      <= '0;
			end_q     <= 1'b0;
			ovalid_q  <= 1'b0;
			m_q       <= '0;
			acc_q     <= '0;
			ctr_q     <= '0;
			num_q     <= '0;
			rem_q     <= '0;
			neg_q     <= 1'b0;
			v_q       <= '0;
			r_q       <= '0;
			bit_q     <= '0;
			x_q       <= '0;
			y_q       <= '0;
			z_q       <= '0;
			res_q     <= '0;
			oval_q    <= '0;
			ocnt_q    <= '0;
		end else begin
			// in ST_DONE the hand-over below sets the flag itself
			if (out_ch.valid && out_ch.ready && state_q != ST_DONE)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_ch.sample_finite) begin
							if (in_ch.sample < min_q) min_q <= in_ch.sample;
							if (in_ch.sample > max_q) max_q <= in_ch.sample;
							sum_q     <= sum_q + SUM_W'(in_ch.sample);
							fin_cnt_q <= fin_cnt_q + 1'b1;
							m_q <= in_ch.sample[31] ? 32'(-in_ch.sample) : 32'(in_ch.sample);
						end else begin
							skip_q <= skip_q + 1'b1;
							m_q    <= '0;
						end
						if (cidx_q == CIDX_W'(0)) begin
							re_q     <= in_ch.sample;
							pf_q[0]  <= in_ch.sample_finite;
						end else if (cidx_q == CIDX_W'(1)) begin
							im_q     <= in_ch.sample;
							pf_q[1]  <= in_ch.sample_finite;
						end
						end_q <= in_ch.last_component ||
							(cidx_q == CIDX_W'(MAX_COMPONENTS - 1));
						if (!(in_ch.last_component ||
							(cidx_q == CIDX_W'(MAX_COMPONENTS - 1))))
							cidx_q <= cidx_q + 1'b1;
						state_q <= ST_SQMUL;
					end
				end
				ST_SQMUL: state_q <= ST_SQACC;
				ST_SQACC: begin
					sq_q    <= sq_q + SQ_W'(prod_q[63:FRAC_BITS]);
					state_q <= end_q ? ST_START : ST_IDLE;
				end
				// choose the finishing unit
				ST_START: begin
					ctr_q <= '0;
					res_q <= '0;
					state_q <= ST_DONE;
					if (fin_cnt_q != '0) begin
						case (mode_q)
							MODE_MIN: res_q <= min_q;
							MODE_MAX: res_q <= max_q;
							MODE_MEAN: begin
								num_q   <= sum_mag + SUM_W'(fin_cnt_q >> 1);
								neg_q   <= sum_q[SUM_W-1];
								rem_q   <= '0;
								state_q <= ST_DIV;
							end
							MODE_MAG: begin
								if (sq_q >= (SQ_W'(1) << (62 - FRAC_BITS))) begin
									res_q <= 32'sh7FFFFFFF;
								end else begin
									v_q     <= 63'(sq_q) << FRAC_BITS;
									r_q     <= '0;
									bit_q   <= 63'(1) << 62;
									state_q <= ST_SQRT;
								end
							end
							default: begin
								if (pf_q == 2'b11 && (re_q != 0 || im_q != 0)) begin
									state_q <= ST_CORD;
									if (re_q < 0) begin
										if (im_q >= 0) begin
											x_q <= CW'(im_q);
											y_q <= -CW'(re_q);
											z_q <= ANG_PI_2;
										end else begin
											x_q <= -CW'(im_q);
											y_q <= CW'(re_q);
											z_q <= -ANG_PI_2;
										end
									end else begin
										x_q <= CW'(re_q);
										y_q <= CW'(im_q);
										z_q <= '0;
									end
								end
							end
						endcase
					end
				end
				// restoring divide, one quotient bit a cycle
				ST_DIV: begin
					rem_q <= div_ge ? CNT_W'(div_t - {1'b0, fin_cnt_q}) : div_t[CNT_W-1:0];
					num_q <= {num_q[SUM_W-2:0], div_ge};
					ctr_q <= ctr_q + 1'b1;
					if (ctr_q == 6'(SUM_W - 1)) state_q <= ST_MFIN;
				end
				ST_MFIN: begin
					res_q   <= sat32(mean_q);
					state_q <= ST_DONE;
				end
				// square root, two radicand bits a cycle
				ST_SQRT: begin
					if (sq_ge) begin
						v_q <= v_q - sq_try;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					ctr_q <= ctr_q + 1'b1;
					if (ctr_q == 6'd31) state_q <= ST_SFIN;
				end
				ST_SFIN: begin
					res_q   <= sq_res[31] ? 32'sh7FFFFFFF : signed'(sq_res[31:0]);
					state_q <= ST_DONE;
				end
				// vectoring CORDIC, one micro-rotation a cycle
				ST_CORD: begin
					if (y_q > 0) begin
						x_q <= x_q + cx_d;
						y_q <= y_q - cy_d;
						z_q <= z_q + c_atan;
					end else begin
						x_q <= x_q - cx_d;
						y_q <= y_q + cy_d;
						z_q <= z_q - c_atan;
					end
					ctr_q <= ctr_q + 1'b1;
					if (ctr_q == 6'(CORDIC_STEPS - 1)) state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					z_q <= z_adj;
					if (mode_q inside {MODE_PH_SD, MODE_PH_UD}) begin
						state_q <= ST_DEG1;
					end else begin
						res_q   <= sat32(wrap_z);
						state_q <= ST_DONE;
					end
				end
				// degrees: low and high parts of the angle times 180/pi
				ST_DEG1: state_q <= ST_DEG2;
				ST_DEG2: begin
					acc_q   <= prod_q;
					state_q <= ST_DEG3;
				end
				ST_DEG3: begin
					res_q   <= sat32(deg_tot);
					state_q <= ST_DONE;
				end
				// hand over to the output register and clear the pixel
				ST_DONE: begin
					if (!ovalid_q || out_ch.ready) begin
						ovalid_q  <= 1'b1;
						oval_q    <= res_q;
						ocnt_q    <= 5'(skip_q);
						min_q     <= 32'sh7FFFFFFF;
						max_q     <= 32'sh80000000;
						sum_q     <= '0;
						sq_q      <= '0;
						fin_cnt_q <= '0;
						skip_q    <= '0;
						cidx_q    <= '0;
						pf_q      <= '0;
						re_q      <= '0;
						im_q      <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ch.ready)
		else $error("input taken while a component is in work");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (fin_cnt_q != '0))
		else $error("mean divide with no finite component");
	a_cordic_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORD) |-> (ctr_q < 6'(CORDIC_STEPS)))
		else $error("CORDIC step count overrun");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_cnt_q + skip_q) <= CNT_W'(MAX_COMPONENTS))
		else $error("component count beyond pixel size");
`endif

endmodule

[tb/pcp_test_if.sv]
// Bench constants: length of the long receiver hold-off.
`timescale 1ns / 100ps
package pcp_test_pkg;
	localparam int LONG_HOLD = 400;
endpackage

[tb/pcp_checker.sv]
// Checker: watches the channels, predicts each pixel result and compares it.
`timescale 1ns / 100ps
module pcp_checker (
	input  logic clk,
	input  logic arst_n,
	pcp_in_if.sink  in_mon,
	pcp_out_if.sink out_mon,
	pcp_cfg_if.sink cfg_mon,
	output int      fail_count,
	output int      pending
);
	import pcp_pkg::*;

	typedef struct packed {
		logic signed [31:0] value;
		logic [4:0]         skipped;
	} pixel_result_t;

	pixel_result_t expected_q[$];

	// predictor copy of the accumulators
	mode_t       mode_reg;
	longint      run_min, run_max, run_sum, re_part, im_part;
	longint unsigned sq_sum;
	int          n_finite, n_skipped, comp_idx;
	logic [1:0]  parts_ok;

	localparam longint PI_2_Q30   = 64'sd1686629713;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint DEG_Q24    = 64'sd961263669;
	localparam longint ATAN_TBL [31] = '{
		'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
		'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
		'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
		'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
		'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
		'h00000001};

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned root_rounded(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (v > r) r++;
		return r;
	endfunction

	// CORDIC vectoring angle, Q2.30
	function automatic longint angle_q30(longint x, longint y);
		longint z, t, dx, dy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = PI_2_Q30;
			end else begin
				t = x; x = -y; y = t; z = -PI_2_Q30;
			end
		end
		for (int i = 0; i < 31; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ATAN_TBL[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TBL[i];
			end
		end
		return z;
	endfunction

	function automatic longint reduce_pixel();
		longint unsigned mag;
		longint q, z;
		if (n_finite == 0) return 0;
		case (mode_reg)
			MODE_MIN: return run_min;
			MODE_MAX: return run_max;
			MODE_MEAN: begin
				mag = run_sum < 0 ? -run_sum : run_sum;
				q = (mag + n_finite / 2) / n_finite;
				return clamp32(run_sum < 0 ? -q : q);
			end
			MODE_MAG: begin
				if (sq_sum >= (64'd1 << (62 - FRAC_BITS))) return 64'sd2147483647;
				return clamp32(root_rounded(sq_sum << FRAC_BITS));
			end
			default: begin
				if (parts_ok != 2'b11) return 0;
				z = angle_q30(re_part, im_part);
				if ((mode_reg inside {MODE_PH_UR, MODE_PH_UD}) && z < 0)
					z += TWO_PI_Q30;
				if (mode_reg inside {MODE_PH_SD, MODE_PH_UD}) begin
					z = z * DEG_Q24;
					return clamp32((z + (64'sd1 << (53 - FRAC_BITS))) >>> (54 - FRAC_BITS));
				end
				return clamp32((z + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
			end
		endcase
	endfunction

	task automatic clear_pixel();
		run_min = 64'sd2147483647;
		run_max = -64'sd2147483648;
		run_sum = 0; sq_sum = 0;
		n_finite = 0; n_skipped = 0; comp_idx = 0;
		re_part = 0; im_part = 0; parts_ok = 0;
	endtask

	task automatic take_component(longint s, logic fin, logic last);
		longint unsigned m;
		pixel_result_t r;
		if (fin) begin
			m = s < 0 ? -s : s;
			if (s < run_min) run_min = s;
			if (s > run_max) run_max = s;
			run_sum += s;
			sq_sum += (m * m) >> FRAC_BITS;
			n_finite++;
		end else begin
			n_skipped++;
		end
		if (comp_idx == 0) begin
			re_part = s;
			if (fin) parts_ok[0] = 1'b1;
		end else if (comp_idx == 1) begin
			im_part = s;
			if (fin) parts_ok[1] = 1'b1;
		end
		if (!last && comp_idx < MAX_COMPONENTS - 1) begin
			comp_idx++;
		end else begin
			r.value = 32'(reduce_pixel());
			r.skipped = n_skipped > 31 ? 5'd31 : 5'(n_skipped);
			expected_q.insert(expected_q.size(), r);
			clear_pixel();
		end
	endtask

	// watch the three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		pixel_result_t exp_r;
		if (!arst_n) begin
			mode_reg = MODE_MIN;
			clear_pixel();
			expected_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready)
				mode_reg = cfg_mon.projection_mode;
			if (out_mon.valid && out_mon.ready) begin
				if (expected_q.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= 10)
						$display("unexpected result value=%0d skipped=%0d",
							out_mon.projected_value, out_mon.ignored_count);
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r.value !== out_mon.projected_value
							|| exp_r.skipped !== out_mon.ignored_count) begin
						fail_count = fail_count + 1;
						if (fail_count <= 10)
							$display("mismatch: value exp %0d got %0d, skipped exp %0d got %0d",
								exp_r.value, out_mon.projected_value,
								exp_r.skipped, out_mon.ignored_count);
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				take_component(longint'(in_mon.sample), in_mon.sample_finite,
					in_mon.last_component);
			pending = expected_q.size();
		end
	end

endmodule

[tb/pixel_component_projection_test.sv]
// Top of the bench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps
module pixel_component_projection_test;
	import pcp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending;
	int   send_idle_pct = 0, recv_idle_pct = 0;
	bit   hold_recv = 1'b0;

	pcp_in_if  in_ch();
	pcp_out_if out_ch();
	pcp_cfg_if cfg();

	pixel_component_projection i_dut (.clk(clk), .arst_n(arst_n),
		.in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

	pcp_checker i_checker (.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.cfg_mon(cfg), .fail_count(fail_count), .pending(pending));

	always #5 clk = ~clk;

	// receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_recv)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one request on the input channel, with random gaps ahead of it;
	// valid stays up after acceptance until the next request or a drain
	task automatic send_component(logic [31:0] s, logic fin, logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		in_ch.sample_finite <= fin;
		in_ch.last_component <= last;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_mode(mode_t m);
		drain();
		cfg.valid <= 1'b1;
		cfg.projection_mode <= m;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'(int'($urandom_range(1 << 18)) - (1 << 17));
			3: return 32'h0;
			default: return $urandom();
		endcase
	endfunction

	// a pixel of random width; mostly well formed, sometimes long
	task automatic send_pixel();
		int n;
		n = $urandom_range(9) == 0 ? $urandom_range(20, 14) : $urandom_range(4, 1);
		for (int k = 0; k < n; k++)
			send_component(rand_sample(), $urandom_range(9) != 0, k == n - 1);
	endtask

	initial begin
		mode_t m;
		in_ch.valid = 0; in_ch.sample = 0; in_ch.sample_finite = 0;
		in_ch.last_component = 0;
		cfg.valid = 0; cfg.projection_mode = MODE_MIN;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every mode over extremes and special cases
		for (int mi = 0; mi < 8; mi++) begin
			m = mode_t'(mi);
			set_mode(m);
			send_component(32'h7FFFFFFF, 1, 0);
			send_component(32'h80000000, 1, 1);
			send_component(32'h0, 1, 0);
			send_component(32'h0, 1, 1);
			send_component(32'h00010000, 0, 0);
			send_component(32'hFFFF0000, 1, 1);
			send_component(32'hFFFFFFFF, 1, 1);
		end
		// more than the maximum components, and all non-finite
		for (int k = 0; k < 17; k++) send_component(32'h12345678, 0, 0);
		send_component(32'h0, 0, 1);

		// random phases with different idling
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 13 : ph == 1 ? 49 : 0;
			recv_idle_pct = ph == 0 ? 49 : ph == 1 ? 13 : 0;
			for (int chunk = 0; chunk < 8; chunk++) begin
				set_mode(chunk == 0 ? MODE_PH_UD : mode_t'($urandom_range(7)));
				if (ph == 2 && chunk == 0) begin
					hold_recv = 1'b1;
					fork
						begin
							repeat (pcp_test_pkg::LONG_HOLD) @(negedge clk);
							hold_recv = 1'b0;
						end
					join_none
				end
				for (int p = 0; p < 16; p++) send_pixel();
			end
		end
		set_mode(MODE_MIN);

		drain();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[pixel_component_projection.f]
hdl/pcp_pkg.sv
hdl/pcp_if.sv
hdl/pixel_component_projection.sv
tb/pcp_test_if.sv
tb/pcp_checker.sv
tb/pixel_component_projection_test.sv
